FILE: src/jvm_integer_stack_core_assert.svh
// Assertion macros for the integer stack core.
// Included by files that check their own control logic; needs i_clk and i_rst_n in scope.
`ifndef JVM_INTEGER_STACK_CORE_ASSERT_SVH
`define JVM_INTEGER_STACK_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define JISC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define JISC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/jisc_pkg.sv
// Package for the integer stack core: opcodes, status codes, sequencer states.
// No dependencies.
package jisc_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int NUM_LOCALS_DEF  = 256;

    localparam logic [7:0] OP_CONST_FIRST  = 8'h03;
    localparam logic [7:0] OP_CONST_LAST   = 8'h08;
    localparam logic [7:0] OP_PUSH_BYTE    = 8'h10;
    localparam logic [7:0] OP_LDC          = 8'h12;
    localparam logic [7:0] OP_LOAD_LOCAL   = 8'h15;
    localparam logic [7:0] OP_LOAD_FIRST   = 8'h1B;
    localparam logic [7:0] OP_LOAD_LAST    = 8'h1D;
    localparam logic [7:0] OP_PUSH_REF_ZERO = 8'h2A;
    localparam logic [7:0] OP_STORE_LOCAL  = 8'h36;
    localparam logic [7:0] OP_STORE_FIRST  = 8'h3C;
    localparam logic [7:0] OP_STORE_LAST   = 8'h3E;
    localparam logic [7:0] OP_DUP          = 8'h59;
    localparam logic [7:0] OP_IADD         = 8'h60;
    localparam logic [7:0] OP_ISUB         = 8'h64;
    localparam logic [7:0] OP_IMUL         = 8'h68;
    localparam logic [7:0] OP_IDIV         = 8'h6C;
    localparam logic [7:0] OP_RETURN       = 8'hB1;
    localparam logic [7:0] OP_STATIC_REF   = 8'hB2;
    localparam logic [7:0] OP_INVOKEVIRT   = 8'hB6;
    localparam logic [7:0] OP_INVOKESPEC   = 8'hB7;
    localparam logic [7:0] OP_NEW          = 8'hBB;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_RET    = 3'd1;
    localparam logic [2:0] ST_UNSUP  = 3'd2;
    localparam logic [2:0] ST_UNDER  = 3'd3;
    localparam logic [2:0] ST_OVER   = 3'd4;
    localparam logic [2:0] ST_DIV0   = 3'd5;
    localparam logic [2:0] ST_BADLOC = 3'd6;

    localparam logic [1:0] LEN_1 = 2'd1;
    localparam logic [1:0] LEN_2 = 2'd2;
    localparam logic [1:0] LEN_3 = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIV,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL
    } t_alu_op;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

endpackage

FILE: src/jisc_if.sv
// Handshake channels of the integer stack core: instruction items in, result items out.
// No dependencies.
interface jisc_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] req_type;
    logic [7:0] operand_hi;
    logic [7:0] operand_lo;

    modport source (output valid, req_type, operand_hi, operand_lo, input ready);
    modport sink   (input valid, req_type, operand_hi, operand_lo, output ready);
endinterface

interface jisc_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [1:0]         length;
    logic signed [31:0] top_value;
    logic               top_is_ref;
    logic [6:0]         stack_count;

    modport source (output valid, status, length, top_value, top_is_ref, stack_count,
                    input ready);
    modport sink   (input valid, status, length, top_value, top_is_ref, stack_count,
                    output ready);
endinterface

FILE: src/jisc_alu.sv
// Shared combinational arithmetic unit: wrapping add, subtract and multiply.
// Depends on jisc_pkg.
module jisc_alu
    import jisc_pkg::*;
(
    input  t_alu_op     i_op,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_y
);

    always_comb begin
        unique case (i_op)
            ALU_ADD: o_y = i_a + i_b;
            ALU_SUB: o_y = i_a - i_b;
            ALU_MUL: o_y = i_a * i_b;
            default: o_y = i_a + i_b;
        endcase
    end

endmodule

FILE: src/jisc_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on jisc_pkg.
module jisc_div
    import jisc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic        r_done;
    logic        r_neg;
    logic [32:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;

    logic [32:0] w_trial;
    logic [32:0] w_shift;

    assign w_shift = {r_rem[31:0], r_quo[31]};
    assign w_trial = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Work on magnitudes; fix the sign once at the end.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.dividend[31] ^ i_req.divisor[31];
            r_rem <= '0;
            r_quo <= i_req.dividend[31] ? (32'd0 - i_req.dividend) : i_req.dividend;
            r_dvs <= i_req.divisor[31] ? (32'd0 - i_req.divisor) : i_req.divisor;
        end else if (r_busy) begin
            if (!w_trial[32]) begin
                r_rem <= w_trial;
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? (32'd0 - r_quo) : r_quo;

endmodule

FILE: src/jvm_integer_stack_core.sv
// Top level of the integer stack core: sequencer, operand stack and local store.
// Depends on jisc_pkg, jisc_if, jisc_alu, jisc_div and jvm_integer_stack_core_assert.svh.
//
// Usage: each item on i_req is one bytecode instruction (opcode plus two operand
// bytes). Each accepted item yields exactly one item on o_rsp holding the status,
// the instruction length, the new top of stack with its reference tag, and the
// stack depth. Items are processed one at a time: i_req.ready is high only while
// the sequencer is idle.
// Steps: accept, read (stack and local memories), execute, present. idiv adds a
// divide step between execute and present that waits on the divider (one quotient
// bit per cycle). The top of stack sits in a register, so pops need
// only the single stack read port for the entry underneath.
// The result sits in an output register; the next item is accepted while it waits.
// If the receiver stalls, a finished item holds in the present step until the output
// register frees up, and no further item is accepted meanwhile.
// Reset empties the stack and zeroes every local through per-entry valid bits; no
// clearing pass is needed. Stack memory contents are undefined until pushed.
`include "jvm_integer_stack_core_assert.svh"

module jvm_integer_stack_core
    import jisc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int NUM_LOCALS  = NUM_LOCALS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jisc_req_if.sink    i_req,
    jisc_rsp_if.source  o_rsp
);

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int LAW = $clog2(NUM_LOCALS);

    // Sequencer and latched instruction
    t_state     r_state, n_state;
    logic [7:0] r_op, r_hi, r_lo;

    // Architectural state
    logic [SPW-1:0] r_sp;
    logic [31:0]    r_top;
    logic           r_top_ref;
    logic [32:0]    stack_mem [STACK_DEPTH];
    logic [31:0]    loc_mem   [NUM_LOCALS];
    logic           r_loc_vld [NUM_LOCALS];

    // Registered memory reads
    logic [32:0] r_nos;
    logic [31:0] r_loc_data;
    logic        r_loc_hit;

    // Item result held for the present step
    logic [2:0] r_status;
    logic [1:0] r_len;

    // Output register
    logic               r_out_valid;
    logic [2:0]         r_out_status;
    logic [1:0]         r_out_len;
    logic signed [31:0] r_out_top;
    logic               r_out_ref;
    logic [6:0]         r_out_cnt;

    // Execute-step decode
    logic [7:0]     w_idx8;
    logic [LAW-1:0] w_loc_idx;
    logic           w_loc_bad;
    logic [31:0]    w_loc_val;
    logic [SAW-1:0] w_nos_addr;
    logic [31:0]    w_arith;
    logic [31:0]    w_alu_y;
    t_alu_op        w_alu_op;
    t_div_req       w_div_req;
    t_div_rsp       w_div_rsp;
    logic           w_commit;
    logic           w_out_free;

    logic [2:0]     x_status;
    logic [1:0]     x_len;
    logic           x_stk_we;
    logic [SAW-1:0] x_stk_addr;
    logic [32:0]    x_stk_data;
    logic [SPW-1:0] x_sp;
    logic [31:0]    x_top;
    logic           x_top_ref;
    logic           x_loc_we;
    logic           x_div_go;
    logic           x_push;
    logic [32:0]    x_push_data;

    assign w_nos_addr = SAW'(r_sp - SPW'(2));
    assign w_out_free = !r_out_valid || o_rsp.ready;

    // Local index: explicit byte for iload/istore, implied for the short forms
    always_comb begin
        case (r_op) inside
            [OP_LOAD_FIRST:OP_LOAD_LAST]:   w_idx8 = r_op - (OP_LOAD_FIRST - 8'd1);
            [OP_STORE_FIRST:OP_STORE_LAST]: w_idx8 = r_op - (OP_STORE_FIRST - 8'd1);
            default:                        w_idx8 = r_hi;
        endcase
    end

    assign w_loc_idx = w_idx8[LAW-1:0];
    assign w_loc_bad = {1'b0, w_idx8} >= 9'(NUM_LOCALS);
    assign w_loc_val = r_loc_hit ? r_loc_data : 32'd0;

    always_comb begin
        unique case (r_op)
            OP_ISUB: w_alu_op = ALU_SUB;
            OP_IMUL: w_alu_op = ALU_MUL;
            default: w_alu_op = ALU_ADD;
        endcase
    end

    jisc_alu u_alu (
        .i_op (w_alu_op),
        .i_a  (r_nos[31:0]),
        .i_b  (r_top),
        .o_y  (w_alu_y)
    );

    assign w_div_req.start    = x_div_go;
    assign w_div_req.dividend = r_nos[31:0];
    assign w_div_req.divisor  = r_top;

    jisc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_arith = (r_op == OP_IDIV) ? w_div_rsp.quotient : w_alu_y;

    // Decode and compute the effect of the latched instruction
    always_comb begin
        x_status    = ST_OK;
        x_len       = LEN_1;
        x_stk_we    = 1'b0;
        x_stk_addr  = r_sp[SAW-1:0];
        x_stk_data  = {r_top_ref, r_top};
        x_sp        = r_sp;
        x_top       = r_top;
        x_top_ref   = r_top_ref;
        x_loc_we    = 1'b0;
        x_div_go    = 1'b0;
        x_push      = 1'b0;
        x_push_data = '0;

        unique case (r_op) inside
            [OP_CONST_FIRST:OP_CONST_LAST]: begin
                x_push      = 1'b1;
                x_push_data = {1'b0, 24'd0, r_op - OP_CONST_FIRST};
            end
            OP_PUSH_BYTE: begin
                x_len       = LEN_2;
                x_push      = 1'b1;
                x_push_data = {1'b0, {24{r_hi[7]}}, r_hi};
            end
            OP_LDC: begin
                x_len       = LEN_2;
                x_push      = 1'b1;
                x_push_data = {1'b1, 24'd0, r_hi};
            end
            OP_STATIC_REF, OP_NEW: begin
                x_len       = LEN_3;
                x_push      = 1'b1;
                x_push_data = {1'b1, 16'd0, r_hi, r_lo};
            end
            OP_PUSH_REF_ZERO: begin
                x_push      = 1'b1;
                x_push_data = {1'b1, 32'd0};
            end
            OP_DUP: begin
                if (r_sp == '0) begin
                    x_status = ST_UNDER;
                end else begin
                    x_push      = 1'b1;
                    x_push_data = {r_top_ref, r_top};
                end
            end
            OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV: begin
                if (r_sp < SPW'(2)) begin
                    x_status = ST_UNDER;
                end else if (r_op == OP_IDIV && r_top == 32'd0) begin
                    x_status = ST_DIV0;
                end else if (r_op == OP_IDIV && r_state == S_EXEC) begin
                    x_div_go = 1'b1;
                end else begin
                    // Pop two, push the result into the lower slot
                    x_stk_we   = 1'b1;
                    x_stk_addr = w_nos_addr;
                    x_stk_data = {1'b0, w_arith};
                    x_sp       = r_sp - SPW'(1);
                    x_top      = w_arith;
                    x_top_ref  = 1'b0;
                end
            end
            OP_LOAD_LOCAL, [OP_LOAD_FIRST:OP_LOAD_LAST]: begin
                if (r_op == OP_LOAD_LOCAL) begin
                    x_len = LEN_2;
                end
                if (w_loc_bad) begin
                    x_status = ST_BADLOC;
                end else begin
                    x_push      = 1'b1;
                    x_push_data = {1'b0, w_loc_val};
                end
            end
            OP_STORE_LOCAL, [OP_STORE_FIRST:OP_STORE_LAST]: begin
                if (r_op == OP_STORE_LOCAL) begin
                    x_len = LEN_2;
                end
                if (w_loc_bad) begin
                    x_status = ST_BADLOC;
                end else if (r_sp == '0) begin
                    x_status = ST_UNDER;
                end else begin
                    // The entry underneath becomes the new top
                    x_loc_we  = 1'b1;
                    x_sp      = r_sp - SPW'(1);
                    x_top     = r_nos[31:0];
                    x_top_ref = r_nos[32];
                end
            end
            OP_RETURN: begin
                x_status = ST_RET;
            end
            OP_INVOKEVIRT, OP_INVOKESPEC: begin
                x_len    = LEN_3;
                x_status = ST_UNSUP;
            end
            default: begin
                x_status = ST_UNSUP;
            end
        endcase

        if (x_push) begin
            if (r_sp >= SPW'(STACK_DEPTH)) begin
                x_status = ST_OVER;
            end else begin
                x_stk_we   = 1'b1;
                x_stk_addr = r_sp[SAW-1:0];
                x_stk_data = x_push_data;
                x_sp       = r_sp + SPW'(1);
                x_top      = x_push_data[31:0];
                x_top_ref  = x_push_data[32];
            end
        end
    end

    // Commit once the instruction has its answer
    assign w_commit = (r_state == S_EXEC && !x_div_go) || (r_state == S_DIV && w_div_rsp.done);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_req.valid) n_state = S_READ;
            S_READ: n_state = S_EXEC;
            S_EXEC: n_state = x_div_go ? S_DIV : S_DONE;
            S_DIV:  if (w_div_rsp.done) n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        i_req.ready       = (r_state == S_IDLE);
        o_rsp.valid       = r_out_valid;
        o_rsp.status      = r_out_status;
        o_rsp.length      = r_out_len;
        o_rsp.top_value   = r_out_top;
        o_rsp.top_is_ref  = r_out_ref;
        o_rsp.stack_count = r_out_cnt;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_sp <= x_sp;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Local valid bits: a local never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LOCALS; i++) begin
                r_loc_vld[i] <= 1'b0;
            end
        end else if (w_commit && x_loc_we) begin
            r_loc_vld[w_loc_idx] <= 1'b1;
        end
    end

    // Payload: latched instruction, top-of-stack cache, result
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_op <= i_req.req_type;
            r_hi <= i_req.operand_hi;
            r_lo <= i_req.operand_lo;
        end
        if (r_state == S_READ) begin
            r_loc_hit <= r_loc_vld[w_loc_idx];
        end
        if (w_commit) begin
            r_top     <= x_top;
            r_top_ref <= x_top_ref;
            r_status  <= x_status;
            r_len     <= x_len;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_status <= r_status;
            r_out_len    <= r_len;
            r_out_top    <= (r_sp != '0) ? r_top : 32'd0;
            r_out_ref    <= (r_sp != '0) ? r_top_ref : 1'b0;
            r_out_cnt    <= 7'(r_sp);
        end
    end

    // Operand stack memory: read the entry under the top, write on commit
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_nos <= stack_mem[w_nos_addr];
        end
        if (w_commit && x_stk_we) begin
            stack_mem[x_stk_addr] <= x_stk_data;
        end
    end

    // Local variable memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_loc_data <= loc_mem[w_loc_idx];
        end
        if (w_commit && x_loc_we) begin
            loc_mem[w_loc_idx] <= r_top;
        end
    end

    // Checks
    `JISC_ASSERT_IMP(a_sp_range, 1'b1, r_sp <= SPW'(STACK_DEPTH), "stack pointer beyond depth")
    `JISC_ASSERT_NXT(a_accept_read, i_req.valid && i_req.ready, r_state == S_READ,
                     "accepted item did not start a read")
    `JISC_ASSERT_IMP(a_div_done, w_div_rsp.done, r_state == S_DIV,
                     "divider finished outside the divide step")
    `JISC_ASSERT_IMP(a_out_load, $rose(r_out_valid), $past(r_state) == S_DONE,
                     "result presented without a finished item")

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for jvm_integer_stack_core: bytecode items in, result items out.
// Depends on jisc_pkg, jisc_if and the core RTL; its own predictor computes every result.
module tb_top;
    import jisc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int      DEPTH      = STACK_DEPTH_DEF;
    localparam int      LOCALS     = NUM_LOCALS_DEF;
    localparam int      CYCLE_CAP  = 400000;
    localparam int      DRAIN_WAIT = 60;
    // An opcode the core does not implement.
    localparam logic [7:0] OP_UNKNOWN = 8'hFE;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  length;
        logic [31:0] top_value;
        logic        top_is_ref;
        logic [6:0]  stack_count;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    jisc_req_if req_ch();
    jisc_rsp_if rsp_ch();

    jvm_integer_stack_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // Predictor state: tagged operand stack, its depth, and the local store.
    logic [31:0] stk_val [DEPTH];
    logic        stk_ref [DEPTH];
    int          stk_depth;
    logic [31:0] locals  [LOCALS];

    t_result     pending_results[$];
    int          mismatches;
    int          results_seen;
    int          items_sent;
    int          cycles;
    bit          gaps_on;
    int          rsp_hold;

    initial begin
        i_clk = 1'b0;
    end
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Signed division truncating toward zero; MIN / -1 wraps back to MIN.
    function automatic logic [31:0] quot_trunc(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic logic [2:0] push_entry(logic [31:0] v, logic is_ref);
        if (stk_depth >= DEPTH) return ST_OVER;
        stk_val[stk_depth] = v;
        stk_ref[stk_depth] = is_ref;
        stk_depth++;
        return ST_OK;
    endfunction

    function automatic logic [2:0] load_local(int idx);
        if (idx >= LOCALS) return ST_BADLOC;
        return push_entry(locals[idx], 1'b0);
    endfunction

    function automatic logic [2:0] store_local(int idx);
        if (idx >= LOCALS) return ST_BADLOC;
        if (stk_depth < 1) return ST_UNDER;
        stk_depth--;
        locals[idx] = stk_val[stk_depth];
        return ST_OK;
    endfunction

    function automatic logic [2:0] arith(logic [7:0] op);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        if (stk_depth < 2) return ST_UNDER;
        b = stk_val[stk_depth-1];
        a = stk_val[stk_depth-2];
        case (op)
            OP_IADD: r = a + b;
            OP_ISUB: r = a - b;
            OP_IMUL: r = a * b;
            default: begin
                if (b == 32'd0) return ST_DIV0;
                r = quot_trunc(a, b);
            end
        endcase
        stk_depth -= 2;
        return push_entry(r, 1'b0);
    endfunction

    // Execute one instruction on the predictor state and form its result item.
    function automatic t_result execute_instr(logic [7:0] op, logic [7:0] hi, logic [7:0] lo);
        t_result r;
        r.status = ST_OK;
        r.length = LEN_1;
        if (op >= OP_CONST_FIRST && op <= OP_CONST_LAST) begin
            r.status = push_entry(32'(op - OP_CONST_FIRST), 1'b0);
        end else if (op >= OP_LOAD_FIRST && op <= OP_LOAD_LAST) begin
            r.status = load_local(op - OP_LOAD_FIRST + 1);
        end else if (op >= OP_STORE_FIRST && op <= OP_STORE_LAST) begin
            r.status = store_local(op - OP_STORE_FIRST + 1);
        end else begin
            case (op)
                OP_PUSH_BYTE: begin
                    r.length = LEN_2;
                    r.status = push_entry({{24{hi[7]}}, hi}, 1'b0);
                end
                OP_LDC: begin
                    r.length = LEN_2;
                    r.status = push_entry({24'd0, hi}, 1'b1);
                end
                OP_STATIC_REF, OP_NEW: begin
                    r.length = LEN_3;
                    r.status = push_entry({16'd0, hi, lo}, 1'b1);
                end
                OP_PUSH_REF_ZERO: r.status = push_entry(32'd0, 1'b1);
                OP_DUP: begin
                    if (stk_depth < 1) r.status = ST_UNDER;
                    else r.status = push_entry(stk_val[stk_depth-1], stk_ref[stk_depth-1]);
                end
                OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV: r.status = arith(op);
                OP_LOAD_LOCAL: begin
                    r.length = LEN_2;
                    r.status = load_local(hi);
                end
                OP_STORE_LOCAL: begin
                    r.length = LEN_2;
                    r.status = store_local(hi);
                end
                OP_RETURN: r.status = ST_RET;
                OP_INVOKEVIRT, OP_INVOKESPEC: begin
                    r.length = LEN_3;
                    r.status = ST_UNSUP;
                end
                default: r.status = ST_UNSUP;
            endcase
        end
        if (stk_depth > 0) begin
            r.top_value  = stk_val[stk_depth-1];
            r.top_is_ref = stk_ref[stk_depth-1];
        end else begin
            r.top_value  = 32'd0;
            r.top_is_ref = 1'b0;
        end
        r.stack_count = 7'(stk_depth);
        return r;
    endfunction

    // Offer one instruction item after a random gap (when gaps are on); predict its result once accepted.
    task automatic send_instr(logic [7:0] op, logic [7:0] hi = 8'h00, logic [7:0] lo = 8'h00);
        int gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= op;
        req_ch.operand_hi <= hi;
        req_ch.operand_lo <= lo;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_results.push_back(execute_instr(op, hi, lo));
        items_sent++;
    endtask

    // Hold until every predicted result has come back.
    task automatic wait_results_drained();
        if (items_sent > 0) req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: stall at random (or for a requested long stretch), then check each item.
    initial begin : result_checker
        int w;
        t_result got;
        t_result want;
        rsp_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            w = (gaps_on ? $urandom_range(0, 4) : 0) + rsp_hold;
            rsp_hold = 0;
            if (w > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
            got = '{rsp_ch.status, rsp_ch.length, rsp_ch.top_value, rsp_ch.top_is_ref,
                    rsp_ch.stack_count};
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item at cycle %0d: %p", cycles, got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d: expected st=%0d len=%0d top=%h ref=%b cnt=%0d",
                                 results_seen, want.status, want.length, want.top_value,
                                 want.top_is_ref, want.stack_count);
                        $display("           got      st=%0d len=%0d top=%h ref=%b cnt=%0d",
                                 got.status, got.length, got.top_value, got.top_is_ref,
                                 got.stack_count);
                    end
                end
            end
        end
    end

    // Every push flavor, field extremes, iadd and idiv, and the underflow, div0 and unsupported codes.
    task automatic test_directed_ops();
        send_instr(OP_DUP);                  // underflow on an empty stack
        send_instr(OP_IADD);
        send_instr(OP_STORE_LOCAL, 8'hFF);   // underflow with the top local index
        send_instr(OP_LOAD_LOCAL, 8'hFF);    // never-stored local reads zero
        for (int k = 0; k <= 5; k++) send_instr(OP_CONST_FIRST + 8'(k));
        send_instr(OP_PUSH_BYTE, 8'h7F);
        send_instr(OP_PUSH_BYTE, 8'h80);     // sign extension
        send_instr(OP_PUSH_BYTE, 8'hFF);
        send_instr(OP_LDC, 8'hFF);
        send_instr(OP_STATIC_REF, 8'hFF, 8'hFF);
        send_instr(OP_NEW, 8'h00, 8'h00);
        send_instr(OP_PUSH_REF_ZERO);
        send_instr(OP_DUP);                  // copies a reference tag
        send_instr(OP_CONST_FIRST);
        send_instr(OP_IDIV);                 // divide by zero leaves the stack alone
        send_instr(OP_RETURN);
        send_instr(OP_INVOKEVIRT, 8'h12, 8'h34);
        send_instr(OP_INVOKESPEC);
        send_instr(OP_UNKNOWN, 8'hFF, 8'hFF);
        send_instr(OP_STORE_LOCAL, 8'hFF);
        send_instr(OP_LOAD_LOCAL, 8'hFF);
        wait_results_drained();
    endtask

    // Build MIN through wrapping multiplies, then MIN / -1, plus the short local forms.
    task automatic test_arith_corners();
        send_instr(OP_PUSH_BYTE, 8'h80);
        send_instr(OP_DUP);
        send_instr(OP_IMUL);                 // 2^14
        send_instr(OP_DUP);
        send_instr(OP_IMUL);                 // 2^28
        send_instr(OP_PUSH_BYTE, 8'h08);
        send_instr(OP_IMUL);                 // wraps to MIN
        send_instr(OP_DUP);
        send_instr(OP_PUSH_BYTE, 8'hFF);
        send_instr(OP_IDIV);                 // MIN / -1 stays MIN
        send_instr(OP_PUSH_BYTE, 8'hF9);
        send_instr(OP_IDIV);                 // truncation toward zero
        send_instr(OP_ISUB);
        for (int k = 0; k < 3; k++) begin
            send_instr(OP_PUSH_BYTE, 8'($urandom));
            send_instr(OP_STORE_FIRST + 8'(k));
            send_instr(OP_LOAD_FIRST + 8'(k));
        end
        wait_results_drained();
    endtask

    // Stall the receiver while pushing past the stack limit, so the core backs up.
    task automatic test_overflow_backpressure();
        rsp_hold = 300;
        for (int k = 0; k < DEPTH + 3; k++) send_instr(OP_PUSH_BYTE, 8'($urandom));
        send_instr(OP_DUP);
        send_instr(OP_PUSH_REF_ZERO);
        while (stk_depth > 0) send_instr(OP_STORE_LOCAL, 8'($urandom));
        wait_results_drained();
    endtask

    // Random instructions steered to keep the stack mid-range; some raw opcodes as noise.
    task automatic test_random_programs(int n);
        int pick;
        logic [7:0] op;
        for (int i = 0; i < n; i++) begin
            if (i % 200 == 0) gaps_on = (i % 400 == 0);
            if (i % 200 == 199) gaps_on = 1'b1;
            pick = $urandom_range(0, 11);
            if (stk_depth > DEPTH - 6 && pick < 6) pick = 6 + (pick % 3);
            if (stk_depth < 3 && pick >= 6 && pick <= 8) pick = pick - 6;
            case (pick)
                0: op = OP_CONST_FIRST + 8'($urandom_range(0, 5));
                1, 2: op = OP_PUSH_BYTE;
                3: begin
                    case ($urandom_range(0, 3))
                        0: op = OP_LDC;
                        1: op = OP_STATIC_REF;
                        2: op = OP_NEW;
                        default: op = OP_PUSH_REF_ZERO;
                    endcase
                end
                4: op = OP_DUP;
                5: op = ($urandom_range(0, 1) != 0) ? OP_LOAD_LOCAL
                        : OP_LOAD_FIRST + 8'($urandom_range(0, 2));
                6, 7: begin
                    case ($urandom_range(0, 3))
                        0: op = OP_IADD;
                        1: op = OP_ISUB;
                        2: op = OP_IMUL;
                        default: op = OP_IDIV;
                    endcase
                end
                8: op = ($urandom_range(0, 1) != 0) ? OP_STORE_LOCAL
                        : OP_STORE_FIRST + 8'($urandom_range(0, 2));
                9: op = ($urandom_range(0, 1) != 0) ? OP_RETURN : OP_INVOKEVIRT;
                default: op = 8'($urandom);
            endcase
            // Keep local indexes in a small set now and then so stores get read back.
            send_instr(op, ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom),
                       8'($urandom));
            if (i == n / 2) wait_results_drained();
        end
        wait_results_drained();
    endtask

    initial begin
        stk_depth         = 0;
        foreach (locals[k]) locals[k] = 32'd0;
        mismatches        = 0;
        results_seen      = 0;
        items_sent        = 0;
        cycles            = 0;
        rsp_hold          = 0;
        gaps_on           = 1'b1;
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = 8'h00;
        req_ch.operand_hi = 8'h00;
        req_ch.operand_lo = 8'h00;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_ops();
        test_arith_corners();
        test_overflow_backpressure();
        test_random_programs(920);

        req_ch.valid <= 1'b0;
        wait_results_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d instruction items and %0d result items: pushes, locals,", items_sent,
                 results_seen);
        $display("wrapping and dividing arithmetic, overflow under a stalled receiver, errors");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
